// ===== design/csvt_pkg.sv =====
// shared types and constants of the csv field and record tokenizer
`timescale 1ns / 1ps

package csvt_pkg;

  localparam int CfgIdxW = 1;
  localparam int CfgDataW = 7;

  localparam logic [CfgIdxW-1:0] CFG_DELIMITER = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_QUOTE = 1'd1;

  localparam logic OP_DATA = 1'b0;
  localparam logic OP_END = 1'b1;

  localparam logic [7:0] CH_CR = 8'h0d;
  localparam logic [7:0] CH_LF = 8'h0a;
  localparam logic [7:0] CH_NUL = 8'h00;

  typedef struct packed {
    logic quoted;
    logic quote_pending;
    logic line_open;
    logic failed;
  } state_t;

  typedef struct packed {
    logic       char_valid;
    logic [7:0] char_out;
    logic       field_end;
    logic       record_end;
    logic       finished;
    logic       null_err;
  } result_t;

endpackage

// ===== design/csvt_step.sv =====
// next state and result word for one input word
`timescale 1ns / 1ps

module csvt_step (
  input  csvt_pkg::state_t  state,
  input  logic              operation,
  input  logic [7:0]        data_byte,
  input  logic [6:0]        delimiter_char,
  input  logic [6:0]        quote_char,
  output csvt_pkg::state_t  state_nxt,
  output logic              res_valid,
  output csvt_pkg::result_t res
);

  logic is_quote;
  logic is_delim;
  logic is_eol;
  logic outside;

  assign is_quote = (data_byte == {1'b0, quote_char});
  assign is_delim = (data_byte == {1'b0, delimiter_char});
  assign is_eol = (data_byte == csvt_pkg::CH_CR) || (data_byte == csvt_pkg::CH_LF);

  always_comb begin
    state_nxt = state;
    res_valid = 1'b0;
    res = '0;
    outside = 1'b0;
    if (state.failed) begin
      res_valid = 1'b0;
    end else if (operation == csvt_pkg::OP_END) begin
      state_nxt.quoted = 1'b0;
      state_nxt.quote_pending = 1'b0;
      state_nxt.line_open = 1'b0;
      res_valid = 1'b1;
      res.field_end = state.line_open;
      res.record_end = state.line_open;
      res.finished = 1'b1;
    end else if (data_byte == csvt_pkg::CH_NUL) begin
      state_nxt.failed = 1'b1;
      res_valid = 1'b1;
      res.null_err = 1'b1;
    end else if (state.quoted) begin
      if (state.quote_pending) begin
        state_nxt.quote_pending = 1'b0;
        if (is_quote) begin
          res_valid = 1'b1;
          res.char_valid = 1'b1;
          res.char_out = data_byte;
        end else begin
          state_nxt.quoted = 1'b0;
          outside = 1'b1;
        end
      end else if (is_quote) begin
        state_nxt.quote_pending = 1'b1;
      end else begin
        state_nxt.line_open = 1'b1;
        res_valid = 1'b1;
        res.char_valid = 1'b1;
        res.char_out = data_byte;
      end
    end else begin
      outside = 1'b1;
    end

    if (outside) begin
      if (is_quote) begin
        state_nxt.quoted = 1'b1;
        state_nxt.line_open = 1'b1;
      end else if (is_eol) begin
        if (state.line_open) begin
          state_nxt.line_open = 1'b0;
          res_valid = 1'b1;
          res.field_end = 1'b1;
          res.record_end = 1'b1;
        end
      end else begin
        state_nxt.line_open = 1'b1;
        res_valid = 1'b1;
        if (is_delim) begin
          res.field_end = 1'b1;
        end else begin
          res.char_valid = 1'b1;
          res.char_out = data_byte;
        end
      end
    end
  end

endmodule

// ===== design/csv_record_field_tokenizer_core.sv =====
// top level of the csv field and record tokenizer
// a result word is registered and shown in the cycle after its input word is accepted
// throughput: one input word per cycle unless a full result register is stalled, set by the single result register
// in_ready stays high while the result register is empty or being taken
// synchronous active-low reset clears the flags and the result valid bit and
// restores the delimiter to ',' and the quote to '"'
`timescale 1ns / 1ps

module csv_record_field_tokenizer_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [csvt_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [csvt_pkg::CfgDataW-1:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_operation,
  input  logic [7:0] in_data_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_char_valid,
  output logic [7:0] out_char_out,
  output logic       out_field_end,
  output logic       out_record_end,
  output logic       out_finished,
  output logic       out_null_err
);

  logic [6:0]        delimiter_r;
  logic [6:0]        quote_r;
  csvt_pkg::state_t  state_r;
  csvt_pkg::state_t  state_nxt;
  logic              out_valid_r;
  csvt_pkg::result_t res_r;
  csvt_pkg::result_t res_nxt;
  logic              res_valid;
  logic              accept;

  csvt_step u_step (
    .state          (state_r),
    .operation      (in_operation),
    .data_byte      (in_data_byte),
    .delimiter_char (delimiter_r),
    .quote_char     (quote_r),
    .state_nxt      (state_nxt),
    .res_valid      (res_valid),
    .res            (res_nxt)
  );

  assign in_ready = !out_valid_r || out_ready;
  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delimiter_r <= 7'd44;
      quote_r <= 7'd34;
    end else if (cfg_we) begin
      case (cfg_index)
        csvt_pkg::CFG_DELIMITER: delimiter_r <= cfg_wdata;
        csvt_pkg::CFG_QUOTE:     quote_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        state_r <= state_nxt;
      end
      if (accept && res_valid) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res_valid) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_char_valid = res_r.char_valid;
  assign out_char_out = res_r.char_out;
  assign out_field_end = res_r.field_end;
  assign out_record_end = res_r.record_end;
  assign out_finished = res_r.finished;
  assign out_null_err = res_r.null_err;

endmodule

// ===== design/csvt_checker.sv =====
// port checks for the csv tokenizer and their binding to the top level
`timescale 1ns / 1ps

module csvt_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_char_valid,
  input logic [7:0] out_char_out,
  input logic       out_field_end,
  input logic       out_record_end,
  input logic       out_finished,
  input logic       out_null_err
);

  // record end always comes with field end
  a_record_with_field: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_record_end || out_field_end))
    else $error("record_end without field_end");

  // a content byte never shares a word with an end or error flag
  a_char_alone: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_char_valid) |->
      !(out_field_end || out_finished || out_null_err))
    else $error("content byte mixed with control flags");

  // nothing follows an encoding error until reset
  a_error_stops: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_null_err) |=> !out_valid)
    else $error("word after encoding error");

  // an empty result register never blocks input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_char_out)))
    else $error("stalled output word changed");

endmodule

bind csv_record_field_tokenizer_core csvt_checker u_csvt_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_char_valid (out_char_valid),
  .out_char_out   (out_char_out),
  .out_field_end  (out_field_end),
  .out_record_end (out_record_end),
  .out_finished   (out_finished),
  .out_null_err   (out_null_err)
);

// ===== tb/sv/tb_csv_record_field_tokenizer_core.sv =====
// testbench for csv_record_field_tokenizer_core: queued text words, random stalls, token checks
`timescale 1ns / 1ps

module tb_csv_record_field_tokenizer_core;

  localparam int CycleLimit = 600000;

  typedef struct packed {
    logic       op;
    logic [7:0] data;
  } text_word_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          cfg_we = 1'b0;
  logic [csvt_pkg::CfgIdxW-1:0]  cfg_index = csvt_pkg::CFG_DELIMITER;
  logic [csvt_pkg::CfgDataW-1:0] cfg_wdata = '0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic                          in_operation = csvt_pkg::OP_DATA;
  logic [7:0]                    in_data_byte = 8'h00;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic                          out_char_valid;
  logic [7:0]                    out_char_out;
  logic                          out_field_end;
  logic                          out_record_end;
  logic                          out_finished;
  logic                          out_null_err;

  text_word_t        text_q[$];
  csvt_pkg::result_t token_q[$];
  text_word_t        next_word;
  csvt_pkg::result_t pred_token;
  csvt_pkg::result_t want_token;

  csvt_pkg::state_t tok_state = '0;
  logic [6:0] delim_reg = 7'd44;
  logic [6:0] quote_reg = 7'd34;

  int  queued_total = 0;
  int  tokens_taken = 0;
  int  mismatches = 0;
  int  cycle_count = 0;
  int  send_gap = 0;
  int  stall_left = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  bit  steady = 1'b0;

  csv_record_field_tokenizer_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_operation   (in_operation),
    .in_data_byte   (in_data_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_char_valid (out_char_valid),
    .out_char_out   (out_char_out),
    .out_field_end  (out_field_end),
    .out_record_end (out_record_end),
    .out_finished   (out_finished),
    .out_null_err   (out_null_err)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // token expected for one text word, or none
  function automatic bit tokenize_word(input logic op, input logic [7:0] b,
                                       output csvt_pkg::result_t r);
    logic [7:0] q;
    logic [7:0] d;
    q = {1'b0, quote_reg};
    d = {1'b0, delim_reg};
    r = '0;
    if (tok_state.failed) return 1'b0;
    if (op == csvt_pkg::OP_END) begin
      r.field_end = tok_state.line_open;
      r.record_end = tok_state.line_open;
      r.finished = 1'b1;
      tok_state.quoted = 1'b0;
      tok_state.quote_pending = 1'b0;
      tok_state.line_open = 1'b0;
      return 1'b1;
    end
    if (b == csvt_pkg::CH_NUL) begin
      tok_state.failed = 1'b1;
      r.null_err = 1'b1;
      return 1'b1;
    end
    if (tok_state.quoted) begin
      if (tok_state.quote_pending) begin
        tok_state.quote_pending = 1'b0;
        if (b == q) begin
          r.char_valid = 1'b1;
          r.char_out = b;
          return 1'b1;
        end
        tok_state.quoted = 1'b0;
      end else begin
        if (b == q) begin
          tok_state.quote_pending = 1'b1;
          return 1'b0;
        end
        tok_state.line_open = 1'b1;
        r.char_valid = 1'b1;
        r.char_out = b;
        return 1'b1;
      end
    end
    if (b == q) begin
      tok_state.quoted = 1'b1;
      tok_state.line_open = 1'b1;
      return 1'b0;
    end
    if (b == csvt_pkg::CH_CR || b == csvt_pkg::CH_LF) begin
      if (!tok_state.line_open) return 1'b0;
      tok_state.line_open = 1'b0;
      r.field_end = 1'b1;
      r.record_end = 1'b1;
      return 1'b1;
    end
    tok_state.line_open = 1'b1;
    if (b == d) begin
      r.field_end = 1'b1;
      return 1'b1;
    end
    r.char_valid = 1'b1;
    r.char_out = b;
    return 1'b1;
  endfunction

  // byte with no special meaning under the current registers
  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    b = 8'($urandom_range(1, 255));
    while (b == {1'b0, quote_reg} || b == {1'b0, delim_reg} ||
           b == csvt_pkg::CH_CR || b == csvt_pkg::CH_LF)
      b = 8'($urandom_range(1, 255));
    return b;
  endfunction

  task automatic push_word(input logic op, input logic [7:0] b);
    text_word_t w;
    w.op = op;
    w.data = b;
    text_q.push_back(w);
    queued_total++;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (text_q.size() != 0 || in_valid || token_q.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic set_config(input logic [6:0] d, input logic [6:0] q);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= csvt_pkg::CFG_DELIMITER;
    cfg_wdata <= d;
    @(posedge clk);
    cfg_index <= csvt_pkg::CFG_QUOTE;
    cfg_wdata <= q;
    @(posedge clk);
    cfg_we <= 1'b0;
    delim_reg = d;
    quote_reg = q;
    @(negedge clk);
  endtask

  task automatic add_noise(input int n);
    int k;
    logic [7:0] b;
    repeat (n) begin
      k = $urandom_range(0, 11);
      case (k)
        0: b = {1'b0, quote_reg};
        1: b = {1'b0, delim_reg};
        2: b = csvt_pkg::CH_CR;
        3: b = csvt_pkg::CH_LF;
        4: b = {1'b1, quote_reg};
        5: b = {1'b1, delim_reg};
        default: b = 8'($urandom_range(1, 255));
      endcase
      if (b == csvt_pkg::CH_NUL) b = 8'h80;
      if (k == 11) push_word(csvt_pkg::OP_END, 8'($urandom_range(0, 255)));
      else push_word(csvt_pkg::OP_DATA, b);
    end
  endtask

  // mostly well-formed records with random content, some noise
  task automatic run_phase(input int n);
    int stop;
    int nf;
    int k;
    logic [7:0] sep;
    logic [7:0] q;
    stop = queued_total + n;
    q = {1'b0, quote_reg};
    add_noise(6);
    while (queued_total < stop) begin
      sep = (delim_reg != 0) ? {1'b0, delim_reg} : plain_byte();
      if ($urandom_range(0, 4) == 0) begin
        add_noise($urandom_range(1, 6));
      end else begin
        nf = $urandom_range(1, 4);
        for (int f = 0; f < nf; f++) begin
          if (f > 0) push_word(csvt_pkg::OP_DATA, sep);
          if (quote_reg != 0 && $urandom_range(0, 2) == 0) begin
            push_word(csvt_pkg::OP_DATA, q);
            repeat ($urandom_range(0, 5)) begin
              k = $urandom_range(0, 9);
              case (k)
                0: push_word(csvt_pkg::OP_DATA, sep);
                1: push_word(csvt_pkg::OP_DATA, csvt_pkg::CH_CR);
                2: push_word(csvt_pkg::OP_DATA, csvt_pkg::CH_LF);
                3: begin
                  push_word(csvt_pkg::OP_DATA, q);
                  push_word(csvt_pkg::OP_DATA, q);
                end
                default: push_word(csvt_pkg::OP_DATA, plain_byte());
              endcase
            end
            push_word(csvt_pkg::OP_DATA, q);
            if ($urandom_range(0, 5) == 0) push_word(csvt_pkg::OP_DATA, plain_byte());
          end else begin
            repeat ($urandom_range(0, 6)) push_word(csvt_pkg::OP_DATA, plain_byte());
          end
        end
        k = $urandom_range(0, 4);
        case (k)
          0: push_word(csvt_pkg::OP_DATA, csvt_pkg::CH_CR);
          1: push_word(csvt_pkg::OP_DATA, csvt_pkg::CH_LF);
          2: begin
            push_word(csvt_pkg::OP_DATA, csvt_pkg::CH_CR);
            push_word(csvt_pkg::OP_DATA, csvt_pkg::CH_LF);
          end
          3: push_word(csvt_pkg::OP_END, 8'($urandom_range(0, 255)));
          default: begin
            push_word(csvt_pkg::OP_DATA, csvt_pkg::CH_CR);
            push_word(csvt_pkg::OP_END, 8'($urandom_range(0, 255)));
          end
        endcase
      end
    end
  endtask

  // text word driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else if (!in_valid || in_ready) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (text_q.size() > 0) begin
        next_word = text_q.pop_front();
        in_valid <= 1'b1;
        in_operation <= next_word.op;
        in_data_byte <= next_word.data;
        send_gap <= pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // token receiver readiness, with one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= (hold_left == 1);
    end else if (!hold_done && tokens_taken > 300 && text_q.size() > 60) begin
      hold_done <= 1'b1;
      hold_left <= 400;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= (stall_left == 1);
    end else if (out_valid && out_ready) begin
      stall_left <= pick_gap();
      out_ready <= steady;
    end else begin
      out_ready <= steady || ($urandom_range(0, 19) != 0);
    end
  end

  // prediction on accepted words, checking of taken tokens
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        if (tokenize_word(in_operation, in_data_byte, pred_token))
          token_q.push_back(pred_token);
      end
      if (out_valid && out_ready) begin
        tokens_taken++;
        if (token_q.size() == 0) begin
          mismatches++;
          $display("%0t: token with none expected, actual cv=%0d ch=%h fe=%0d re=%0d fin=%0d err=%0d",
                   $time, out_char_valid, out_char_out, out_field_end, out_record_end,
                   out_finished, out_null_err);
        end else begin
          want_token = token_q.pop_front();
          if (want_token.char_valid !== out_char_valid) begin
            mismatches++;
            $display("%0t: char_valid expected %0d actual %0d", $time,
                     want_token.char_valid, out_char_valid);
          end
          if (want_token.char_out !== out_char_out) begin
            mismatches++;
            $display("%0t: char_out expected %h actual %h", $time, want_token.char_out, out_char_out);
          end
          if (want_token.field_end !== out_field_end) begin
            mismatches++;
            $display("%0t: field_end expected %0d actual %0d", $time,
                     want_token.field_end, out_field_end);
          end
          if (want_token.record_end !== out_record_end) begin
            mismatches++;
            $display("%0t: record_end expected %0d actual %0d", $time,
                     want_token.record_end, out_record_end);
          end
          if (want_token.finished !== out_finished) begin
            mismatches++;
            $display("%0t: finished expected %0d actual %0d", $time,
                     want_token.finished, out_finished);
          end
          if (want_token.null_err !== out_null_err) begin
            mismatches++;
            $display("%0t: null_err expected %0d actual %0d", $time,
                     want_token.null_err, out_null_err);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("%0t: timeout, %0d tokens still expected", $time, token_q.size());
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // default registers: quoting, escapes, crlf, high bytes, end of input
    push_word(csvt_pkg::OP_DATA, "a");
    push_word(csvt_pkg::OP_DATA, ",");
    push_word(csvt_pkg::OP_DATA, "\"");
    push_word(csvt_pkg::OP_DATA, "x");
    push_word(csvt_pkg::OP_DATA, "\"");
    push_word(csvt_pkg::OP_DATA, "\"");
    push_word(csvt_pkg::OP_DATA, "\"");
    push_word(csvt_pkg::OP_DATA, ",");
    push_word(csvt_pkg::OP_DATA, 8'hff);
    push_word(csvt_pkg::OP_DATA, 8'hac);
    push_word(csvt_pkg::OP_DATA, 8'ha2);
    push_word(csvt_pkg::OP_DATA, "b");
    push_word(csvt_pkg::OP_DATA, "\"");
    push_word(csvt_pkg::OP_DATA, csvt_pkg::CH_CR);
    push_word(csvt_pkg::OP_DATA, csvt_pkg::CH_LF);
    push_word(csvt_pkg::OP_DATA, ",");
    push_word(csvt_pkg::OP_DATA, "\"");
    push_word(csvt_pkg::OP_DATA, csvt_pkg::CH_CR);
    push_word(csvt_pkg::OP_DATA, csvt_pkg::CH_LF);
    push_word(csvt_pkg::OP_DATA, csvt_pkg::CH_LF);
    push_word(csvt_pkg::OP_DATA, 8'h01);
    push_word(csvt_pkg::OP_END, 8'hff);
    push_word(csvt_pkg::OP_END, 8'h00);
    push_word(csvt_pkg::OP_DATA, "\"");
    push_word(csvt_pkg::OP_DATA, "z");
    push_word(csvt_pkg::OP_END, 8'h5a);
    wait_idle();

    set_config(7'd9, 7'd39);
    run_phase(185);
    wait_idle();
    set_config(7'd127, 7'd0);
    run_phase(185);
    wait_idle();
    set_config(7'd0, 7'd127);
    run_phase(185);
    wait_idle();
    set_config(7'd13, 7'd10);
    run_phase(185);
    wait_idle();
    set_config(7'd34, 7'd34);
    run_phase(185);
    wait_idle();
    set_config(7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
    steady = 1'b1;
    run_phase(185);
    wait_idle();
    steady = 1'b0;
    set_config(7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
    run_phase(185);
    wait_idle();
    set_config(7'd44, 7'd34);
    run_phase(150);

    // null inside quotes, then the tokenizer stays silent
    push_word(csvt_pkg::OP_DATA, "\"");
    push_word(csvt_pkg::OP_DATA, "a");
    push_word(csvt_pkg::OP_DATA, csvt_pkg::CH_NUL);
    push_word(csvt_pkg::OP_DATA, "b");
    push_word(csvt_pkg::OP_END, 8'h00);
    push_word(csvt_pkg::OP_DATA, ",");
    push_word(csvt_pkg::OP_DATA, csvt_pkg::CH_CR);
    wait_idle();
    repeat (10) @(negedge clk);

    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/csvt_pkg.sv
design/csvt_step.sv
design/csv_record_field_tokenizer_core.sv
design/csvt_checker.sv
tb/sv/tb_csv_record_field_tokenizer_core.sv
